// ===== rtl/crbb_pkg.sv =====
package crbb_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 24;
	localparam int CUTOFF_BITS = 18;

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SQ_W = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 2;
	localparam int CUTSQ_W = 2 * CUTOFF_BITS;
	localparam int CMP_W = (SUM_W > CUTSQ_W) ? SUM_W : CUTSQ_W;
	localparam int POINT_W = 3 * COORD_BITS;

	localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = CUTOFF_BITS'(32768);
	localparam logic [CUTSQ_W-1:0] CUTSQ_RESET =
		CUTSQ_W'(CUTOFF_RESET) * CUTSQ_W'(CUTOFF_RESET);

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	// axis 0 is x, 1 is y, 2 is z
	typedef coord_t [2:0] point_t;

	typedef struct packed {
		action_t                  action;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic signed [COORD_BITS-1:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic                     found_any;
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_min_y;
		logic signed [COORD_BITS-1:0] box_min_z;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_max_y;
		logic signed [COORD_BITS-1:0] box_max_z;
		logic                     load_overflow;
	} out_item_t;

	typedef struct packed {
		logic             load_a;
		logic             load_b;
		logic             clear;
		logic             start;
		logic             pair_valid;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic             publish;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt_a;
		logic [CNT_W-1:0] cnt_b;
		logic             pipe_busy;
		logic             out_busy;
	} status_t;

endpackage

// ===== rtl/crbb_ram.sv =====
module crbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/crbb_ctrl.sv =====
module crbb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  crbb_pkg::action_t   action,
	input  crbb_pkg::status_t   status,
	output crbb_pkg::cmd_t      cmd
);

	import crbb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] ia_q;
	logic [IDX_W-1:0] ib_q;
	logic             accept;
	logic             last_a;
	logic             last_b;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign last_a   = (CNT_W'(ia_q) == status.cnt_a - CNT_W'(1));
	assign last_b   = (CNT_W'(ib_q) == status.cnt_b - CNT_W'(1));

	always_comb begin
		cmd            = '0;
		cmd.load_a     = accept & (action == ACT_LOAD_A);
		cmd.load_b     = accept & (action == ACT_LOAD_B);
		cmd.clear      = accept & (action == ACT_CLEAR);
		cmd.start      = accept & (action == ACT_COMPUTE);
		cmd.pair_valid = (state_q == ST_WALK);
		cmd.idx_a      = ia_q;
		cmd.idx_b      = ib_q;
		cmd.publish    = (state_q == ST_FINISH) & ~status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ia_q    <= '0;
			ib_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					ia_q <= '0;
					ib_q <= '0;
					if (cmd.start) begin
						if ((status.cnt_a != '0) && (status.cnt_b != '0)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_WALK: begin
					if (last_a) begin
						ia_q <= '0;
						if (last_b) begin
							state_q <= ST_DRAIN;
						end else begin
							ib_q <= ib_q + IDX_W'(1);
						end
					end else begin
						ia_q <= ia_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/crbb_dp.sv =====
module crbb_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  crbb_pkg::in_item_t                     in_data,
	input  logic                                   cfg_we,
	input  logic [crbb_pkg::CUTOFF_BITS-1:0]       cfg_data,
	input  crbb_pkg::cmd_t                         cmd,
	output crbb_pkg::status_t                      status,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output crbb_pkg::out_item_t                    out_data
);

	import crbb_pkg::*;

	logic [CNT_W-1:0]       cnt_a_q;
	logic [CNT_W-1:0]       cnt_b_q;
	logic                   ovf_q;
	logic [CUTOFF_BITS-1:0] cutoff_q;
	logic [CUTSQ_W-1:0]     cut_sq_q;
	logic                   full_a;
	logic                   full_b;
	point_t                 load_pt;
	logic [POINT_W-1:0]     rd_a;
	logic [POINT_W-1:0]     rd_b;
	point_t                 pa;
	point_t                 pb;

	logic                   v_s1, v_s2, v_s3, v_s4;
	point_t                 pa_s2, pb_s2, pa_s3, pb_s3, pa_s4, pb_s4;
	coord_t [2:0]           d_s2;
	logic [2:0][SQ_W-1:0]   sq_s3;
	logic                   hit_s4;
	logic [CMP_W-1:0]       sum;

	logic                   seen_q;
	point_t                 lo_q;
	point_t                 hi_q;
	point_t                 pmin;
	point_t                 pmax;
	logic                   out_valid_q;
	out_item_t              out_q;

	assign full_a  = (cnt_a_q == CNT_W'(MAX_POINTS));
	assign full_b  = (cnt_b_q == CNT_W'(MAX_POINTS));
	assign load_pt = {in_data.coord_z, in_data.coord_y, in_data.coord_x};

	// point stores, one read per cycle during the pair walk
	crbb_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram_a (
		.clk   (clk),
		.we    (cmd.load_a & ~full_a),
		.waddr (cnt_a_q[IDX_W-1:0]),
		.wdata (load_pt),
		.raddr (cmd.idx_a),
		.rdata (rd_a)
	);

	crbb_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram_b (
		.clk   (clk),
		.we    (cmd.load_b & ~full_b),
		.waddr (cnt_b_q[IDX_W-1:0]),
		.wdata (load_pt),
		.raddr (cmd.idx_b),
		.rdata (rd_b)
	);

	assign pa = rd_a;
	assign pb = rd_b;

	// counts, sticky overflow, cutoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			ovf_q    <= 1'b0;
			cutoff_q <= CUTOFF_RESET;
			cut_sq_q <= CUTSQ_RESET;
		end else begin
			cut_sq_q <= CUTSQ_W'(cutoff_q) * CUTSQ_W'(cutoff_q);
			if (cfg_we) begin
				cutoff_q <= cfg_data;
			end
			if (cmd.clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.load_a) begin
					if (full_a) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_a_q <= cnt_a_q + CNT_W'(1);
					end
				end
				if (cmd.load_b) begin
					if (full_b) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_b_q <= cnt_b_q + CNT_W'(1);
					end
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// absolute differences, squares, compare
	always_ff @(posedge clk) begin
		logic signed [COORD_BITS:0] diff;
		pa_s2 <= pa;
		pb_s2 <= pb;
		for (int k = 0; k < 3; k++) begin
			diff = $signed({pa[k][COORD_BITS-1], pa[k]})
				- $signed({pb[k][COORD_BITS-1], pb[k]});
			d_s2[k] <= diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
		end
		pa_s3 <= pa_s2;
		pb_s3 <= pb_s2;
		for (int k = 0; k < 3; k++) begin
			sq_s3[k] <= SQ_W'(d_s2[k]) * SQ_W'(d_s2[k]);
		end
		pa_s4  <= pa_s3;
		pb_s4  <= pb_s3;
		hit_s4 <= (sum < CMP_W'(cut_sq_q));
	end

	assign sum = CMP_W'(sq_s3[0]) + CMP_W'(sq_s3[1]) + CMP_W'(sq_s3[2]);

	// both points of a close pair widen the box
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if ($signed(pa_s4[k]) < $signed(pb_s4[k])) begin
				pmin[k] = pa_s4[k];
				pmax[k] = pb_s4[k];
			end else begin
				pmin[k] = pb_s4[k];
				pmax[k] = pa_s4[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else if (cmd.start) begin
			seen_q <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else if (v_s4 && hit_s4) begin
			seen_q <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				if (!seen_q || ($signed(pmin[k]) < $signed(lo_q[k]))) begin
					lo_q[k] <= pmin[k];
				end
				if (!seen_q || ($signed(pmax[k]) > $signed(hi_q[k]))) begin
					hi_q[k] <= pmax[k];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_q.found_any     <= seen_q;
			out_q.box_min_x     <= lo_q[0];
			out_q.box_min_y     <= lo_q[1];
			out_q.box_min_z     <= lo_q[2];
			out_q.box_max_x     <= hi_q[0];
			out_q.box_max_y     <= hi_q[1];
			out_q.box_max_z     <= hi_q[2];
			out_q.load_overflow <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_q;
	assign status.cnt_a     = cnt_a_q;
	assign status.cnt_b     = cnt_b_q;
	assign status.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;
	assign status.out_busy  = out_valid_q;

endmodule

// ===== rtl/contact_region_bounding_box.sv =====
// contact region bounding box: points are loaded into set a or set b one per
// transfer (action 0 or 1), action 3 empties both sets and clears the sticky
// overflow flag, and action 2 runs the contact search and returns one result.
// the search walks every pair of set a against set b through a four stage
// distance pipeline fed by one read port of each point ram, so one pair
// enters per cycle; a compute transfer therefore holds the input stalled
// while the pairs are walked, the pipeline drains and the result is handed
// off, with a further wait if the previous result has not yet been taken.
// loads and clears are accepted while a result waits on the output. a point
// closer than the cutoff (strict, compared as squares) to any point of the
// other set widens the box; with no such pair found_any is low and the box
// is all zero. loads into a full set are dropped and raise load_overflow
// until the next clear. the point rams come up undefined and need no clearing
// pass, as only loaded entries are ever read. the user must write the cutoff
// through cfg_we and cfg_data only while idle; the block does not enforce it
module contact_region_bounding_box (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  crbb_pkg::in_item_t               in_data,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output crbb_pkg::out_item_t              out_data,
	// cutoff register, unsigned q6.12
	input  logic                             cfg_we,
	input  logic [crbb_pkg::CUTOFF_BITS-1:0] cfg_data
);

	import crbb_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: accepts transfers, steps the pair indices, hands off result
	crbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (in_data.action),
		.status   (status),
		.cmd      (cmd)
	);

	// point stores, distance pipeline, box accumulator and result register
	crbb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/crbb_checker.sv =====
module crbb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input crbb_pkg::in_item_t               in_data,
	input logic                             out_valid,
	input logic                             out_stall,
	input crbb_pkg::out_item_t              out_data,
	input logic                             cfg_we,
	input logic [crbb_pkg::CUTOFF_BITS-1:0] cfg_data
);

	import crbb_pkg::*;

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an empty box reads as zero
	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found_any |->
			out_data.box_min_x == '0 && out_data.box_min_y == '0 &&
			out_data.box_min_z == '0 && out_data.box_max_x == '0 &&
			out_data.box_max_y == '0 && out_data.box_max_z == '0)
		else $error("box not zero without a contact");

	// corners ordered
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found_any |->
			out_data.box_min_x <= out_data.box_max_x &&
			out_data.box_min_y <= out_data.box_max_y &&
			out_data.box_min_z <= out_data.box_max_z)
		else $error("box corners out of order");

	// a compute transfer always occupies the input side afterwards
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACT_COMPUTE |=> in_stall)
		else $error("input free right after a compute transfer");

endmodule

bind contact_region_bounding_box crbb_checker u_crbb_checker (.*);

// ===== tb/sv/contact_box_checker.sv =====
`timescale 1ns / 1ps

module contact_box_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  crbb_pkg::in_item_t               in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  crbb_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [crbb_pkg::CUTOFF_BITS-1:0] cfg_data,
	output int                               fail_count,
	output int                               pending
);
	import crbb_pkg::*;

	typedef logic signed [COORD_BITS-1:0] scoord_t;
	typedef struct packed {
		scoord_t x;
		scoord_t y;
		scoord_t z;
	} xyz_t;

	xyz_t                   pts_a [MAX_POINTS];
	xyz_t                   pts_b [MAX_POINTS];
	int                     n_a;
	int                     n_b;
	bit                     dropped;
	logic [CUTOFF_BITS-1:0] cutoff;
	out_item_t              box_q [$];
	int                     mismatches;

	function automatic longint gap_sq(xyz_t p, xyz_t q);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'($signed(p.x)) - longint'($signed(q.x));
		dy = longint'($signed(p.y)) - longint'($signed(q.y));
		dz = longint'($signed(p.z)) - longint'($signed(q.z));
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// pair walk over both sets, then the box around every flagged point
	function automatic out_item_t contact_box();
		bit        near_a [MAX_POINTS];
		bit        near_b [MAX_POINTS];
		longint    lim;
		bit        seen;
		bit        hit;
		xyz_t      p;
		xyz_t      lo;
		xyz_t      hi;
		out_item_t res;
		int        i;
		int        j;
		int        k;
		lim = longint'(cutoff) * longint'(cutoff);
		seen = 1'b0;
		lo = '0;
		hi = '0;
		for (i = 0; i < MAX_POINTS; i++) begin
			near_a[i] = 1'b0;
			near_b[i] = 1'b0;
		end
		for (i = 0; i < n_b; i++)
			for (j = 0; j < n_a; j++)
				if (gap_sq(pts_b[i], pts_a[j]) < lim) begin
					near_b[i] = 1'b1;
					near_a[j] = 1'b1;
				end
		for (k = 0; k < n_a + n_b; k++) begin
			if (k < n_a) begin
				p = pts_a[k];
				hit = near_a[k];
			end else begin
				p = pts_b[k - n_a];
				hit = near_b[k - n_a];
			end
			if (hit) begin
				if (!seen) begin
					lo = p;
					hi = p;
					seen = 1'b1;
				end else begin
					if (p.x < lo.x) lo.x = p.x;
					if (p.y < lo.y) lo.y = p.y;
					if (p.z < lo.z) lo.z = p.z;
					if (p.x > hi.x) hi.x = p.x;
					if (p.y > hi.y) hi.y = p.y;
					if (p.z > hi.z) hi.z = p.z;
				end
			end
		end
		res = '0;
		res.found_any = seen;
		res.box_min_x = lo.x;
		res.box_min_y = lo.y;
		res.box_min_z = lo.z;
		res.box_max_x = hi.x;
		res.box_max_y = hi.y;
		res.box_max_z = hi.z;
		res.load_overflow = dropped;
		return res;
	endfunction

	task automatic check_field(string name, logic [COORD_BITS-1:0] want,
		logic [COORD_BITS-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		xyz_t      pt;
		if (!arst_n) begin
			n_a = 0;
			n_b = 0;
			dropped = 1'b0;
			cutoff = CUTOFF_RESET;
			box_q.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				cutoff = cfg_data;
			if (out_valid && !out_stall) begin
				if (box_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with none pending", $time);
				end else begin
					want = box_q.pop_front();
					check_field("found_any", COORD_BITS'(want.found_any),
						COORD_BITS'(out_data.found_any));
					check_field("box_min_x", want.box_min_x, out_data.box_min_x);
					check_field("box_min_y", want.box_min_y, out_data.box_min_y);
					check_field("box_min_z", want.box_min_z, out_data.box_min_z);
					check_field("box_max_x", want.box_max_x, out_data.box_max_x);
					check_field("box_max_y", want.box_max_y, out_data.box_max_y);
					check_field("box_max_z", want.box_max_z, out_data.box_max_z);
					check_field("load_overflow", COORD_BITS'(want.load_overflow),
						COORD_BITS'(out_data.load_overflow));
				end
			end
			if (in_valid && !in_stall) begin
				pt.x = in_data.coord_x;
				pt.y = in_data.coord_y;
				pt.z = in_data.coord_z;
				case (in_data.action)
					ACT_LOAD_A: begin
						if (n_a < MAX_POINTS) begin
							pts_a[n_a] = pt;
							n_a++;
						end else
							dropped = 1'b1;
					end
					ACT_LOAD_B: begin
						if (n_b < MAX_POINTS) begin
							pts_b[n_b] = pt;
							n_b++;
						end else
							dropped = 1'b1;
					end
					ACT_COMPUTE: box_q = {box_q, contact_box()};
					default: begin
						n_a = 0;
						n_b = 0;
						dropped = 1'b0;
					end
				endcase
			end
			fail_count <= mismatches;
			pending <= box_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import crbb_pkg::*;

	typedef logic signed [COORD_BITS-1:0] scoord_t;

	localparam int CMAX = 2 ** (COORD_BITS - 1) - 1;
	localparam int CMIN = -(2 ** (COORD_BITS - 1));

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_data;
	logic                   cfg_we;
	logic [CUTOFF_BITS-1:0] cfg_data;

	int                     fail_count;
	int                     pending;

	// stimulus-side bookkeeping, only used to shape the traffic
	logic [CUTOFF_BITS-1:0] cutoff_now = CUTOFF_RESET;
	int                     cnt_a;
	int                     cnt_b;
	int                     items_sent;
	int                     computes_sent;
	bit                     steady;
	bit                     hold_req;

	always #6 clk = ~clk;

	contact_region_bounding_box dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	contact_box_checker watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// any value over the full signed range, so every coordinate bit toggles
	function automatic scoord_t any_coord();
		return scoord_t'($urandom);
	endfunction

	// cluster centre, sometimes pinned to an end of the range
	function automatic int pick_centre();
		scoord_t c;
		int      r;
		r = $urandom_range(0, 9);
		c = scoord_t'($urandom);
		if (r == 0)
			return CMAX;
		if (r == 1)
			return CMIN;
		return int'(c);
	endfunction

	// point near a centre, within twice the reach per axis, clamped to the range
	function automatic scoord_t near(int centre, int reach);
		int v;
		v = centre + int'($urandom_range(0, 4 * reach)) - 2 * reach;
		if (v > CMAX)
			v = CMAX;
		if (v < CMIN)
			v = CMIN;
		return scoord_t'(v);
	endfunction

	// one input transfer: hold valid until the block takes it, then maybe idle
	task automatic send(action_t act, scoord_t x, scoord_t y, scoord_t z);
		in_item_t item;
		int       r;
		int       n;
		item.action = act;
		item.coord_x = x;
		item.coord_y = y;
		item.coord_z = z;
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		case (act)
			ACT_LOAD_A: cnt_a++;
			ACT_LOAD_B: cnt_b++;
			ACT_COMPUTE: computes_sent++;
			default: begin
				cnt_a = 0;
				cnt_b = 0;
			end
		endcase
		// mostly back to back, some short gaps, a few long ones
		if (!steady) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				n = 0;
			else if (r < 92)
				n = $urandom_range(1, 3);
			else if (r < 98)
				n = $urandom_range(4, 10);
			else
				n = $urandom_range(20, 60);
			if (n > 0) begin
				in_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	// sender pause until every box is back, plus a margin for trailing loads
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (16) @(posedge clk);
	endtask

	// only called once the block is drained
	task automatic write_cutoff(logic [CUTOFF_BITS-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cutoff_now = v;
	endtask

	// well-formed sequence: a cluster split over both sets, then a compute
	task automatic contact_burst();
		scoord_t ax [8];
		scoord_t ay [8];
		scoord_t az [8];
		int      cx;
		int      cy;
		int      cz;
		int      reach;
		int      na;
		int      nb;
		int      k;
		int      j;
		reach = (cutoff_now == 0) ? 1024 : int'(cutoff_now);
		if (cnt_a + cnt_b > 20 || $urandom_range(0, 2) == 0)
			send(ACT_CLEAR, any_coord(), any_coord(), any_coord());
		cx = pick_centre();
		cy = pick_centre();
		cz = pick_centre();
		na = $urandom_range(1, 6);
		nb = $urandom_range(1, 6);
		k = 0;
		while (na + nb > 0) begin
			if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 1)) begin
				ax[k] = near(cx, reach);
				ay[k] = near(cy, reach);
				az[k] = near(cz, reach);
				send(ACT_LOAD_A, ax[k], ay[k], az[k]);
				k++;
				na--;
			end else begin
				// an exact copy matters for the smallest cutoffs
				if (k > 0 && $urandom_range(0, 3) == 0) begin
					j = $urandom_range(0, k - 1);
					send(ACT_LOAD_B, ax[j], ay[j], az[j]);
				end else
					send(ACT_LOAD_B, near(cx, reach), near(cy, reach), near(cz, reach));
				nb--;
			end
		end
		send(ACT_COMPUTE, any_coord(), any_coord(), any_coord());
	endtask

	// broken sequence: only one set gets points, sometimes none at all
	task automatic one_sided();
		action_t side;
		int      n;
		send(ACT_CLEAR, any_coord(), any_coord(), any_coord());
		side = ($urandom_range(0, 1) == 1) ? ACT_LOAD_A : ACT_LOAD_B;
		n = $urandom_range(0, 4);
		repeat (n) send(side, any_coord(), any_coord(), any_coord());
		send(ACT_COMPUTE, any_coord(), any_coord(), any_coord());
		if ($urandom_range(0, 2) == 0)
			send(ACT_COMPUTE, any_coord(), any_coord(), any_coord());
	endtask

	// fill one set past capacity, compute against a few partners, then clear and compute again
	task automatic overflow_fill();
		action_t full_set;
		action_t other_set;
		int      cx;
		int      cy;
		int      cz;
		int      reach;
		int      n;
		int      extra;
		reach = (cutoff_now == 0) ? 1024 : int'(cutoff_now);
		send(ACT_CLEAR, any_coord(), any_coord(), any_coord());
		full_set = ($urandom_range(0, 1) == 1) ? ACT_LOAD_A : ACT_LOAD_B;
		other_set = (full_set == ACT_LOAD_A) ? ACT_LOAD_B : ACT_LOAD_A;
		cx = pick_centre();
		cy = pick_centre();
		cz = pick_centre();
		extra = $urandom_range(1, 4);
		for (n = 0; n < MAX_POINTS + extra; n++)
			send(full_set, near(cx, 8 * reach), near(cy, 8 * reach), near(cz, 8 * reach));
		repeat ($urandom_range(1, 3))
			send(other_set, near(cx, reach), near(cy, reach), near(cz, reach));
		send(ACT_COMPUTE, any_coord(), any_coord(), any_coord());
		// clear drops the sticky overflow again
		send(ACT_CLEAR, any_coord(), any_coord(), any_coord());
		send(ACT_COMPUTE, any_coord(), any_coord(), any_coord());
	endtask

	// result side: random stalls, calm stretches, and one long hold on request
	initial begin : receiver
		int r;
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long hold-off, counted here, while the sender keeps going
				out_stall <= 1'b1;
				n = 400;
				hold_req = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					out_stall <= 1'b1;
					n = (r < 2) ? $urandom_range(20, 80) : $urandom_range(1, 3);
				end else if (r < 25) begin
					out_stall <= 1'b0;
					n = $urandom_range(50, 200);
				end else begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 4);
				end
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin : stimulus
		int seq;
		int r;
		int step;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		hold_req = 1'b0;
		steady = 1'b0;
		cnt_a = 0;
		cnt_b = 0;
		items_sent = 0;
		computes_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, cutoff still at its reset value of 8.0
		// compute on two empty sets, coordinates of a compute are ignored
		send(ACT_COMPUTE, scoord_t'(CMAX), scoord_t'(CMIN), 24'sh123456);
		// range extremes, each with an identical or near partner in the other set
		send(ACT_LOAD_A, scoord_t'(CMIN), scoord_t'(CMIN), scoord_t'(CMIN));
		send(ACT_LOAD_B, scoord_t'(CMIN), scoord_t'(CMIN), scoord_t'(CMIN));
		send(ACT_LOAD_A, scoord_t'(CMAX), scoord_t'(CMAX), scoord_t'(CMAX));
		send(ACT_LOAD_B, scoord_t'(CMAX), scoord_t'(CMAX), scoord_t'(CMAX - 33));
		send(ACT_COMPUTE, '0, '0, '0);
		// clear with junk coordinates
		send(ACT_CLEAR, 24'sh5a5a5a, -24'sh0a5a5a, 24'sh7fffff);
		// exactly at the cutoff is not a contact, one step inside is
		send(ACT_LOAD_A, '0, '0, '0);
		send(ACT_LOAD_B, 24'sd32768, '0, '0);
		send(ACT_COMPUTE, '0, '0, '0);
		send(ACT_LOAD_B, '0, -24'sd32767, '0);
		send(ACT_COMPUTE, '0, '0, '0);
		// set a empty, set b loaded
		send(ACT_CLEAR, '0, '0, '0);
		send(ACT_LOAD_B, 24'sd1, 24'sd2, 24'sd3);
		send(ACT_COMPUTE, '0, '0, '0);
		// set b empty, set a loaded
		send(ACT_CLEAR, '0, '0, '0);
		send(ACT_LOAD_A, 24'sd5, 24'sd5, 24'sd5);
		send(ACT_COMPUTE, '0, '0, '0);
		drain();

		// random part, the cutoff walks through its extremes between phases
		seq = 0;
		step = 0;
		while (items_sent < 1700 || computes_sent < 60) begin
			if (seq % 8 == 0) begin
				drain();
				case (step % 6)
					0: write_cutoff(CUTOFF_BITS'(262143));
					1: write_cutoff('0);
					2: write_cutoff(CUTOFF_BITS'(1));
					3: write_cutoff(CUTOFF_BITS'($urandom_range(0, 262143)));
					4: write_cutoff(CUTOFF_RESET);
					default: write_cutoff(CUTOFF_BITS'($urandom_range(2, 4096)));
				endcase
				step++;
			end
			steady = ($urandom_range(0, 3) == 0);
			// block fills up behind a held result
			if (seq == 3 || seq == 40 || $urandom_range(0, 49) == 0)
				hold_req = 1'b1;
			if (seq == 12)
				overflow_fill();
			r = $urandom_range(0, 99);
			if (r < 15) begin
				// noise: any action, any coordinates
				repeat ($urandom_range(1, 4))
					send(action_t'($urandom_range(0, 3)), any_coord(), any_coord(),
						any_coord());
			end else if (r < 25)
				one_sided();
			else
				contact_burst();
			if ($urandom_range(0, 9) == 0)
				drain();
			seq++;
		end

		// wait out the last results, then a tail to catch strays
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin : watchdog
		#50000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
